// ===== hdl/btok_pkg.sv =====
// Shared types and constants for the bencode tokenizer.
// Depends on nothing; every other file of the block uses it by scoped name.
package btok_pkg;

    // Parser modes.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_INT_FIRST,
        MODE_INT_DIGITS,
        MODE_STR_LEN,
        MODE_STR_BYTES,
        MODE_ERROR
    } t_mode;

    // Event codes given with each byte.
    typedef enum logic [2:0] {
        EV_NONE   = 3'd0,
        EV_INT    = 3'd1,
        EV_LIST   = 3'd2,
        EV_DICT   = 3'd3,
        EV_CLOSE  = 3'd4,
        EV_STRLEN = 3'd5,
        EV_BYTE   = 3'd6,
        EV_ERROR  = 3'd7
    } t_event_kind;

    // Status of one decimal digit step.
    typedef struct packed {
        logic lead_zero;
        logic over_pos;
        logic over_neg;
    } t_digit_flags;

    // Marker bytes of the format.
    localparam logic [7:0] CH_INT   = 8'h69;
    localparam logic [7:0] CH_LIST  = 8'h6C;
    localparam logic [7:0] CH_DICT  = 8'h64;
    localparam logic [7:0] CH_END   = 8'h65;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    // Width of the event value port.
    localparam int VALUE_W = 64;

endpackage

// ===== hdl/btok_digit.sv =====
// Decimal accumulate step: computes ten times the accumulator plus a digit
// and flags a leading zero or a magnitude past either limit. Uses btok_pkg.
module btok_digit #(
    parameter int INT_BITS = 64
) (
    input  logic [INT_BITS-1:0]  i_acc,
    input  logic                 i_seen,
    input  logic [3:0]           i_digit,
    output logic [INT_BITS-1:0]  o_sum,
    output btok_pkg::t_digit_flags o_flags
);

    localparam int SW = INT_BITS + 4;
    localparam logic [SW-1:0] POS_LIM = (SW'(1) << (INT_BITS - 1)) - SW'(1);
    localparam logic [SW-1:0] NEG_LIM = SW'(1) << (INT_BITS - 1);

    logic [SW-1:0] full_sum;

    // Multiply by ten as two shifts and add the digit.
    assign full_sum = (SW'(i_acc) << 3) + (SW'(i_acc) << 1) + SW'(i_digit);
    assign o_sum    = full_sum[INT_BITS-1:0];

    // A zero already taken may not be followed by another digit.
    assign o_flags.lead_zero = i_seen && (i_acc == '0);
    assign o_flags.over_pos  = full_sum > POS_LIM;
    assign o_flags.over_neg  = full_sum > NEG_LIM;

endmodule

// ===== hdl/btok_fsm.sv =====
// Parser state and per-byte event logic of the bencode tokenizer.
// Uses btok_pkg and the digit step in btok_digit.
module btok_fsm #(
    parameter int MAX_DEPTH = 32,
    parameter int INT_BITS  = 64,
    parameter int DW        = 6
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_fire,
    input  logic [7:0]            i_byte,
    output logic [2:0]            o_kind,
    output logic [btok_pkg::VALUE_W-1:0] o_value,
    output logic [DW-1:0]         o_depth
);

    localparam int VW = btok_pkg::VALUE_W;

    btok_pkg::t_mode         r_mode, n_mode;
    logic [DW-1:0]           r_depth, n_depth;
    logic [INT_BITS-1:0]     r_acc, n_acc;
    logic                    r_neg, n_neg;
    logic                    r_seen, n_seen;
    logic [INT_BITS-2:0]     r_rem, n_rem;

    logic [INT_BITS-1:0]     sum;
    btok_pkg::t_digit_flags  flags;
    btok_pkg::t_event_kind   kind;
    logic [VW-1:0]           value;
    logic                    fail;
    logic                    is_digit;
    logic [INT_BITS-2:0]     rem_dec;

    btok_digit #(
        .INT_BITS (INT_BITS)
    ) u_digit (
        .i_acc   (r_acc),
        .i_seen  (r_seen),
        .i_digit (i_byte[3:0]),
        .o_sum   (sum),
        .o_flags (flags)
    );

    assign is_digit = i_byte inside {[btok_pkg::CH_ZERO:btok_pkg::CH_NINE]};
    assign rem_dec  = (r_rem != '0) ? r_rem - 1'b1 : r_rem;

    // Next state and event for the byte in the input register.
    always_comb begin
        n_mode  = r_mode;
        n_depth = r_depth;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_seen  = r_seen;
        n_rem   = r_rem;
        kind    = btok_pkg::EV_NONE;
        value   = '0;
        fail    = 1'b0;
        case (r_mode)
            btok_pkg::MODE_IDLE: begin
                if (i_byte == btok_pkg::CH_INT) begin
                    n_mode = btok_pkg::MODE_INT_FIRST;
                    n_acc  = '0;
                    n_neg  = 1'b0;
                    n_seen = 1'b0;
                end else if (i_byte == btok_pkg::CH_LIST || i_byte == btok_pkg::CH_DICT) begin
                    if (r_depth >= DW'(MAX_DEPTH)) begin
                        fail = 1'b1;
                    end else begin
                        n_depth = r_depth + 1'b1;
                        kind    = (i_byte == btok_pkg::CH_LIST) ? btok_pkg::EV_LIST
                                                                 : btok_pkg::EV_DICT;
                    end
                end else if (i_byte == btok_pkg::CH_END) begin
                    if (r_depth == '0) begin
                        fail = 1'b1;
                    end else begin
                        n_depth = r_depth - 1'b1;
                        kind    = btok_pkg::EV_CLOSE;
                    end
                end else if (is_digit) begin
                    n_mode = btok_pkg::MODE_STR_LEN;
                    n_acc  = INT_BITS'(i_byte[3:0]);
                    n_neg  = 1'b0;
                    n_seen = 1'b1;
                end else begin
                    fail = 1'b1;
                end
            end
            btok_pkg::MODE_INT_FIRST, btok_pkg::MODE_INT_DIGITS: begin
                if (i_byte == btok_pkg::CH_MINUS && r_mode == btok_pkg::MODE_INT_FIRST) begin
                    n_neg  = 1'b1;
                    n_mode = btok_pkg::MODE_INT_DIGITS;
                end else if (is_digit) begin
                    if (flags.lead_zero || (r_neg ? flags.over_neg : flags.over_pos)) begin
                        fail = 1'b1;
                    end else begin
                        n_acc  = sum;
                        n_seen = 1'b1;
                    end
                    n_mode = btok_pkg::MODE_INT_DIGITS;
                end else if (i_byte == btok_pkg::CH_END && r_seen
                             && !(r_neg && r_acc == '0)) begin
                    kind   = btok_pkg::EV_INT;
                    value  = r_neg ? VW'(0) - VW'(r_acc) : VW'(r_acc);
                    n_mode = btok_pkg::MODE_IDLE;
                end else begin
                    fail = 1'b1;
                end
            end
            btok_pkg::MODE_STR_LEN: begin
                if (is_digit) begin
                    if (flags.lead_zero || flags.over_pos) begin
                        fail = 1'b1;
                    end else begin
                        n_acc  = sum;
                        n_seen = 1'b1;
                    end
                end else if (i_byte == btok_pkg::CH_COLON) begin
                    kind   = btok_pkg::EV_STRLEN;
                    value  = VW'(r_acc);
                    n_rem  = r_acc[INT_BITS-2:0];
                    n_mode = (r_acc == '0) ? btok_pkg::MODE_IDLE : btok_pkg::MODE_STR_BYTES;
                end else begin
                    fail = 1'b1;
                end
            end
            btok_pkg::MODE_STR_BYTES: begin
                kind  = btok_pkg::EV_BYTE;
                value = VW'(i_byte);
                n_rem = rem_dec;
                if (rem_dec == '0) begin
                    n_mode = btok_pkg::MODE_IDLE;
                end
            end
            default: begin
                fail = 1'b1;
            end
        endcase
        // Any failure lands in the sticky error mode.
        if (fail) begin
            n_mode = btok_pkg::MODE_ERROR;
            kind   = btok_pkg::EV_ERROR;
            value  = '0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= btok_pkg::MODE_IDLE;
            r_depth <= '0;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_seen  <= 1'b0;
            r_rem   <= '0;
        end else if (i_fire) begin
            r_mode  <= n_mode;
            r_depth <= n_depth;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_seen  <= n_seen;
            r_rem   <= n_rem;
        end
    end

    assign o_kind  = kind;
    assign o_value = value;
    assign o_depth = n_depth;

endmodule

// ===== hdl/bencode_tokenizer.sv =====
// Top level of the bencode tokenizer: input register, parser and result
// register. Uses btok_pkg and btok_fsm.
//
// Usage:
//   Input channel: i_in_valid, i_in_byte, with o_in_stall back. One byte is
//   one transaction. Output channel: o_out_valid, o_event_kind,
//   o_event_value, o_nest_level, with i_out_stall back. Every byte gives
//   exactly one output transaction, in order.
//   Path: a byte taken into the input register is parsed from there, and its
//   event is stored in the result register when the result slot is free,
//   which a stall of the receiver can hold off.
//   Throughput: one byte per cycle while the receiver does not stall. The
//   parser mode, depth and accumulator are updated in the same cycle in
//   which a byte is parsed, so that state loop sets the rate.
//   Reset (synchronous, active low) empties both registers and returns the
//   parser to idle at depth zero with no error.
//   When the receiver stalls, the result register holds its event; one more
//   byte may still be taken into the input register, after which
//   o_in_stall rises until the result is taken.
//   An error is sticky: every later byte gives the error event until reset.
module bencode_tokenizer #(
    parameter int MAX_DEPTH = 32,
    parameter int INT_BITS  = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_in_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_event_kind,
    output logic signed [63:0] o_event_value,
    output logic [5:0]  o_nest_level
);

    localparam int DW = $clog2(MAX_DEPTH + 1);
    localparam int VW = btok_pkg::VALUE_W;

    logic          r_in_valid;
    logic [7:0]    r_in_byte;
    logic          r_out_valid;
    logic [2:0]    r_kind;
    logic [VW-1:0] r_value;
    logic [5:0]    r_level;

    logic          out_free;
    logic          fire;
    logic          in_take;
    logic [2:0]    kind;
    logic [VW-1:0] value;
    logic [DW-1:0] depth;

    // Handshake: the result slot is free when empty or being taken.
    assign out_free   = !r_out_valid || !i_out_stall;
    assign fire       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    btok_fsm #(
        .MAX_DEPTH (MAX_DEPTH),
        .INT_BITS  (INT_BITS),
        .DW        (DW)
    ) u_fsm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_byte  (r_in_byte),
        .o_kind  (kind),
        .o_value (value),
        .o_depth (depth)
    );

    // Valid flags of the two registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (fire) begin
                r_in_valid <= 1'b0;
            end
            if (fire) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_byte <= i_in_byte;
        end
        if (fire) begin
            r_kind  <= kind;
            r_value <= value;
            r_level <= 6'(depth);
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_event_kind  = r_kind;
    assign o_event_value = r_value;
    assign o_nest_level  = r_level;

    // The input side never stalls while the input register is empty.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_valid |-> !o_in_stall)
        else $error("input stalled with an empty input register");

    // Events without a value carry zero.
    a_zero_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_event_kind == btok_pkg::EV_NONE
            || o_event_kind == btok_pkg::EV_LIST || o_event_kind == btok_pkg::EV_DICT
            || o_event_kind == btok_pkg::EV_CLOSE || o_event_kind == btok_pkg::EV_ERROR)
        |-> o_event_value == '0)
        else $error("nonzero value on an event without a value");

    // A string byte event carries one byte.
    a_byte_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_event_kind == btok_pkg::EV_BYTE |-> o_event_value[63:8] == '0)
        else $error("string byte event out of byte range");

endmodule
